[rtl/core/tpk_pkg.sv]
// tpk_pkg: widths and class codes shared by the triangle perimeter and kind block
// no dependencies; compiled first
package tpk_pkg;

	// coordinate and arithmetic widths
	localparam int CoordWidth = 16;
	localparam int DiffWidth  = 16;
	localparam int ProdWidth  = 2 * DiffWidth;
	localparam int SqWidth    = ProdWidth + 1;
	localparam int RootWidth  = (SqWidth + 1) / 2;
	localparam int PerWidth   = 19;
	localparam int KindWidth  = 2;

	// triangle class codes
	localparam logic [KindWidth-1:0] KindEquilateral = 2'd0;
	localparam logic [KindWidth-1:0] KindIsosceles   = 2'd1;
	localparam logic [KindWidth-1:0] KindScalene     = 2'd2;

endpackage

[rtl/core/tpk_if.sv]
// tpk_if: valid/ready channels for point triples and classified results
// depends on tpk_pkg
interface tpk_pts_if;
	import tpk_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [CoordWidth-1:0]  ax;
	logic signed [CoordWidth-1:0]  ay;
	logic signed [CoordWidth-1:0]  bx;
	logic signed [CoordWidth-1:0]  by_coord;
	logic signed [CoordWidth-1:0]  cx;
	logic signed [CoordWidth-1:0]  cy;

	modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
	modport sink (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

interface tpk_res_if;
	import tpk_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PerWidth-1:0]   perimeter;
	logic [KindWidth-1:0]  kind;

	modport source (output valid, perimeter, kind, input ready);
	modport sink (input valid, perimeter, kind, output ready);
endinterface

[rtl/core/tpk_isqrt.sv]
// tpk_isqrt: pipelined floor square root, one result bit per register stage
// depends on tpk_pkg; instantiated by triangle_perimeter_and_kind
module tpk_isqrt (
	input  logic                           clk,
	input  logic                           en,
	input  logic [tpk_pkg::SqWidth-1:0]    sq,
	output logic [tpk_pkg::RootWidth-1:0]  root
);
	import tpk_pkg::*;

	localparam int TrialWidth = SqWidth + 2;

	logic [SqWidth-1:0]   rem_s [RootWidth];
	logic [RootWidth-1:0] q_s   [RootWidth];

	for (genvar k = 0; k < RootWidth; k++) begin : g_step
		localparam int Bit = RootWidth - 1 - k;

		logic [SqWidth-1:0]    rem_in;
		logic [RootWidth-1:0]  q_in;
		logic [TrialWidth-1:0] rem_ext;
		logic [TrialWidth-1:0] trial;
		logic                  take;

		if (k == 0) begin : g_first
			assign rem_in = sq;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign q_in   = q_s[k-1];
		end

		// (2q + 2^bit) * 2^bit; q has no bits below bit+1 so an or suffices
		assign rem_ext = {{(TrialWidth-SqWidth){1'b0}}, rem_in};
		assign trial   = ({{(TrialWidth-RootWidth){1'b0}}, q_in} << (Bit + 1))
			| (TrialWidth'(1) << (2 * Bit));
		assign take    = rem_ext >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					rem_s[k] <= SqWidth'(rem_ext - trial);
					q_s[k]   <= q_in | (RootWidth'(1) << Bit);
				end else begin
					rem_s[k] <= rem_in;
					q_s[k]   <= q_in;
				end
			end
		end
	end

	assign root = q_s[RootWidth-1];

endmodule

[rtl/core/triangle_perimeter_and_kind.sv]
// Triangle perimeter and kind: takes one transaction of three signed Q8.8
// points per cycle unless stalled and returns the perimeter (sum of the three
// floored side lengths, unsigned Q.8) and the class (equilateral, isosceles,
// scalene). Sides are compared on their exact squared lengths, so two sides
// are equal only when their squared lengths match bit for bit; degenerate
// triangles get no special treatment. Throughput is one triangle per clock
// unless stalled. The pipe runs through absolute differences, squares, squared
// sums, 17 square root stages (one root bit each) and the final sum. The whole
// pipeline advances together whenever the output register is empty or being
// taken, so a stalled result holds the pipe and nothing is lost or repeated.
// No state is kept between transactions and no clearing is needed.
// Depends on tpk_pkg, tpk_if and tpk_isqrt.
module triangle_perimeter_and_kind (
	input  logic       clk,
	input  logic       arst_n,
	tpk_pts_if.sink    points,
	tpk_res_if.source  result
);
	import tpk_pkg::*;

	localparam int SqrtStages = RootWidth;

	// pipeline advance for every stage
	logic en;

	// stage 1: absolute coordinate differences
	logic                 valid_s1;
	logic [DiffWidth-1:0] ab_dx_s1, ab_dy_s1, bc_dx_s1, bc_dy_s1, ca_dx_s1, ca_dy_s1;

	// stage 2: squares
	logic                 valid_s2;
	logic [ProdWidth-1:0] ab_xx_s2, ab_yy_s2, bc_xx_s2, bc_yy_s2, ca_xx_s2, ca_yy_s2;

	// stage 3: squared side lengths
	logic                 valid_s3;
	logic [SqWidth-1:0]   sa_s3, sb_s3, sc_s3;

	// square root stages, with valid and class traveling alongside
	logic [SqrtStages-1:0] vld_sq;
	logic [KindWidth-1:0]  kind_sq [SqrtStages];
	logic [RootWidth-1:0]  root_a, root_b, root_c;
	logic [KindWidth-1:0]  kind_next;

	// output register
	logic                  out_valid_q;
	logic [PerWidth-1:0]   perimeter_q;
	logic [KindWidth-1:0]  kind_q;

	function automatic logic [DiffWidth-1:0] abs_diff(
		input logic signed [CoordWidth-1:0] p,
		input logic signed [CoordWidth-1:0] q
	);
		logic signed [CoordWidth:0] d;
		d = $signed({p[CoordWidth-1], p}) - $signed({q[CoordWidth-1], q});
		if (d < 0) begin
			abs_diff = DiffWidth'(-d);
		end else begin
			abs_diff = DiffWidth'(d);
		end
	endfunction

	assign en           = !out_valid_q || result.ready;
	assign points.ready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			vld_sq      <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= points.valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			vld_sq      <= {vld_sq[SqrtStages-2:0], valid_s3};
			out_valid_q <= vld_sq[SqrtStages-1];
		end
	end

	// differences, squares and sums
	always_ff @(posedge clk) begin
		if (en) begin
			ab_dx_s1 <= abs_diff(points.ax, points.bx);
			ab_dy_s1 <= abs_diff(points.ay, points.by_coord);
			bc_dx_s1 <= abs_diff(points.bx, points.cx);
			bc_dy_s1 <= abs_diff(points.by_coord, points.cy);
			ca_dx_s1 <= abs_diff(points.cx, points.ax);
			ca_dy_s1 <= abs_diff(points.cy, points.ay);

			ab_xx_s2 <= ab_dx_s1 * ab_dx_s1;
			ab_yy_s2 <= ab_dy_s1 * ab_dy_s1;
			bc_xx_s2 <= bc_dx_s1 * bc_dx_s1;
			bc_yy_s2 <= bc_dy_s1 * bc_dy_s1;
			ca_xx_s2 <= ca_dx_s1 * ca_dx_s1;
			ca_yy_s2 <= ca_dy_s1 * ca_dy_s1;

			sa_s3 <= SqWidth'(ab_xx_s2) + SqWidth'(ab_yy_s2);
			sb_s3 <= SqWidth'(bc_xx_s2) + SqWidth'(bc_yy_s2);
			sc_s3 <= SqWidth'(ca_xx_s2) + SqWidth'(ca_yy_s2);
		end
	end

	// class from exact squared lengths
	always_comb begin
		if (sa_s3 == sb_s3 && sb_s3 == sc_s3) begin
			kind_next = KindEquilateral;
		end else if (sa_s3 == sb_s3 || sa_s3 == sc_s3 || sb_s3 == sc_s3) begin
			kind_next = KindIsosceles;
		end else begin
			kind_next = KindScalene;
		end
	end

	// class rides along the square root stages
	always_ff @(posedge clk) begin
		if (en) begin
			kind_sq[0] <= kind_next;
			for (int i = 1; i < SqrtStages; i++) begin
				kind_sq[i] <= kind_sq[i-1];
			end
		end
	end

	tpk_isqrt u_sqrt_a (.clk(clk), .en(en), .sq(sa_s3), .root(root_a));
	tpk_isqrt u_sqrt_b (.clk(clk), .en(en), .sq(sb_s3), .root(root_b));
	tpk_isqrt u_sqrt_c (.clk(clk), .en(en), .sq(sc_s3), .root(root_c));

	// perimeter and output register; three 17-bit roots fit 19 bits
	always_ff @(posedge clk) begin
		if (en) begin
			perimeter_q <= PerWidth'(root_a) + PerWidth'(root_b) + PerWidth'(root_c);
			kind_q      <= kind_sq[SqrtStages-1];
		end
	end

	assign result.valid     = out_valid_q;
	assign result.perimeter = perimeter_q;
	assign result.kind      = kind_q;

	// a result only appears when the last root stage held a transaction
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(vld_sq[SqrtStages-1]))
		else $error("result valid without a transaction in the last root stage");

	// stalled pipe keeps its valid bits
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_sq == $past(vld_sq))
		else $error("root stage valid bits moved during a stall");

	// three coincident points classify as equilateral
	a_zero_equilateral: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en && sa_s3 == '0 && sb_s3 == '0 && sc_s3 == '0)
		|=> kind_sq[0] == KindEquilateral)
		else $error("coincident points not classed equilateral");

	// all squared lengths distinct means scalene
	a_distinct_scalene: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en && sa_s3 != sb_s3 && sb_s3 != sc_s3 && sa_s3 != sc_s3)
		|=> kind_sq[0] == KindScalene)
		else $error("distinct sides not classed scalene");

endmodule
